@@ rtl/core/rtc_pkg.sv @@
package rtc_pkg;

	localparam int unsigned TPS_W = 24;
	localparam int unsigned TICK_W = 28;
	localparam int unsigned IVL_W = 4;
	localparam int unsigned CCNT_W = 5;
	localparam int unsigned DIGIT_COUNT = 14;

	localparam logic [TPS_W-1:0] TPS_RESET = 24'd62500;
	localparam logic [IVL_W-1:0] IVL_DEFAULT = 4'd10;
	localparam logic [CCNT_W-1:0] STRING_LEN = 5'd17;
	localparam logic [CCNT_W-1:0] CCNT_MAX = 5'd31;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
	localparam logic [1:0] STATUS_REJECTED = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_in;
		logic       last_char;
	} rtc_item_t;

	typedef struct packed {
		logic        interval_done;
		logic [1:0]  set_status;
		logic        time_valid;
		logic [6:0]  seconds;
		logic [6:0]  minutes;
		logic [6:0]  hours;
		logic [7:0]  day;
		logic [6:0]  month;
		logic [13:0] year;
	} rtc_result_t;

endpackage

@@ rtl/core/rtc_time_of_day_counter.sv @@
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tdata char_in, tlast last_char, tuser operation
// m_*      out  m_tvalid/m_tready  tdata date, time and status of one word
// cfg_*    in   cfg_wr_en          ticks per second, written on any enabled edge
//
// Each accepted word gives exactly one result word. The word waits in the
// input register while the update logic works on it; the result register
// then loads the update, so the result word passes both registers before it
// can be taken. A new word can enter every cycle unless m_tready stalls.
// Reset clears the clock to all zeros, invalid, interval 10 s, tick rate
// 62500. A stalled m_tready holds the result and, once the input register is
// also full, drops s_tready.
module rtc_time_of_day_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // last_char
	input  logic        s_tuser,   // operation: 0 character, 1 timer tick
	output logic        m_tvalid,
	input  logic        m_tready,
	// [13:0] year, [20:14] month, [28:21] day, [35:29] hours, [42:36] minutes,
	// [49:43] seconds, [50] time_valid, [52:51] set_status, [53] interval_done
	output logic [55:0] m_tdata
);

	rtc_pkg::rtc_item_t   item_in, item_s1;
	rtc_pkg::rtc_result_t result_d, result_q;
	logic                 item_valid, out_free, step;

	assign item_in.operation = s_tuser;
	assign item_in.char_in = s_tdata;
	assign item_in.last_char = s_tlast;

	// advance the state whenever a buffered word can move into the result register
	assign step = item_valid && out_free;

	rtc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.item_in    (item_in),
		.take       (step),
		.item_valid (item_valid),
		.item_out   (item_s1)
	);

	rtc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.item        (item_s1),
		.result      (result_d)
	);

	rtc_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.result_in  (result_d),
		.free       (out_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.result_out (result_q)
	);

	// pack the result word, year in the lowest bits, zero fill to whole bytes
	assign m_tdata = {2'b00, result_q};

endmodule

@@ rtl/core/rtc_in_reg.sv @@
module rtc_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  rtc_pkg::rtc_item_t item_in,
	input  logic              take,
	output logic              item_valid,
	output rtc_pkg::rtc_item_t item_out
);

	logic              valid_s1;
	rtc_pkg::rtc_item_t item_s1;
	logic              accept;

	assign s_tready = !valid_s1 || take;
	assign accept = s_tvalid && s_tready;
	assign item_valid = valid_s1;
	assign item_out = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule

@@ rtl/core/rtc_core.sv @@
module rtc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rtc_pkg::TPS_W-1:0]   cfg_wr_data,
	input  logic                        step,
	input  rtc_pkg::rtc_item_t          item,
	output rtc_pkg::rtc_result_t        result
);

	logic [rtc_pkg::TPS_W-1:0]  tps_q;
	logic [13:0]                year_q;
	logic [6:0]                 month_q;
	logic [7:0]                 day_q;
	logic [6:0]                 hours_q;
	logic [6:0]                 minutes_q;
	logic [6:0]                 seconds_q;
	logic                       valid_q;
	logic [rtc_pkg::IVL_W-1:0]  ivl_q;
	logic [rtc_pkg::TICK_W-1:0] tick_q;
	logic [rtc_pkg::CCNT_W-1:0] ccnt_q;
	logic                       bad_q;
	logic [3:0]                 digits_q [rtc_pkg::DIGIT_COUNT];

	function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
		two_digits = 7'(7'(hi) * 7'd10 + 7'(lo));
	endfunction

	// character path
	logic       is_char, is_tick;
	logic       in_range, slot_ok, is_digit, bad_d, accept_set;
	logic [3:0] slot, digit, last_digit;
	logic [6:0] yh, yl;

	always_comb begin
		slot = 4'd0;
		slot_ok = 1'b1;
		case (ccnt_q)
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7: slot = ccnt_q[3:0];
			5'd9, 5'd10: slot = 4'(ccnt_q - 5'd1);
			5'd12, 5'd13: slot = 4'(ccnt_q - 5'd2);
			5'd15, 5'd16: slot = 4'(ccnt_q - 5'd3);
			default: slot_ok = 1'b0;
		endcase
	end

	assign is_char = step && (item.operation == rtc_pkg::OP_CHAR);
	assign is_tick = step && (item.operation == rtc_pkg::OP_TICK);
	assign in_range = ccnt_q < rtc_pkg::STRING_LEN;
	assign is_digit = (item.char_in >= 8'h30) && (item.char_in <= 8'h39);
	assign digit = 4'(item.char_in - 8'h30);
	assign bad_d = bad_q || !in_range || (slot_ok && !is_digit);
	assign accept_set = item.last_char && !bad_d
		&& (ccnt_q == rtc_pkg::STRING_LEN - 5'd1);
	// the final seconds digit arrives with the closing character
	assign last_digit = digit;
	assign yh = two_digits(digits_q[0], digits_q[1]);
	assign yl = two_digits(digits_q[2], digits_q[3]);

	// tick path
	logic [rtc_pkg::TICK_W-1:0] tick_inc, limit;
	logic                       ivl_end;

	assign tick_inc = tick_q + 28'd1;
	assign limit = 28'(tps_q) * 28'(ivl_q);
	assign ivl_end = tick_inc >= limit;

	// interval advance with carries
	logic [7:0] s_sum, m_sum, h_sum, s_adv, m_adv, h_adv, d_adv;
	logic       c_min, c_hr;
	logic [2:0] c_day;

	always_comb begin
		s_sum = 8'(seconds_q) + 8'(ivl_q);
		c_min = s_sum >= 8'd60;
		s_adv = c_min ? 8'(s_sum - 8'd60) : s_sum;
		m_sum = 8'(minutes_q) + 8'(c_min);
		c_hr = m_sum >= 8'd60;
		m_adv = c_hr ? 8'(m_sum - 8'd60) : m_sum;
		h_sum = 8'(hours_q) + 8'(c_hr);
		if (h_sum >= 8'd96) begin
			c_day = 3'd4;
		end else if (h_sum >= 8'd72) begin
			c_day = 3'd3;
		end else if (h_sum >= 8'd48) begin
			c_day = 3'd2;
		end else if (h_sum >= 8'd24) begin
			c_day = 3'd1;
		end else begin
			c_day = 3'd0;
		end
		h_adv = 8'(h_sum - 8'(c_day) * 8'd24);
		d_adv = 8'(day_q + 8'(c_day));
	end

	// next state
	logic [13:0]                year_d;
	logic [6:0]                 month_d, hours_d, minutes_d, seconds_d;
	logic [7:0]                 day_d;
	logic                       valid_d, done_d;
	logic [rtc_pkg::IVL_W-1:0]  ivl_d;
	logic [rtc_pkg::TICK_W-1:0] tick_d;
	logic [rtc_pkg::CCNT_W-1:0] ccnt_d;
	logic                       bad_n;
	logic [1:0]                 status_d;

	always_comb begin
		year_d = year_q;
		month_d = month_q;
		day_d = day_q;
		hours_d = hours_q;
		minutes_d = minutes_q;
		seconds_d = seconds_q;
		valid_d = valid_q;
		ivl_d = ivl_q;
		tick_d = tick_q;
		ccnt_d = ccnt_q;
		bad_n = bad_q;
		status_d = rtc_pkg::STATUS_NONE;
		done_d = 1'b0;
		if (is_tick) begin
			tick_d = tick_inc;
			if (ivl_end) begin
				seconds_d = s_adv[6:0];
				minutes_d = m_adv[6:0];
				hours_d = h_adv[6:0];
				day_d = d_adv;
				tick_d = '0;
				ivl_d = rtc_pkg::IVL_DEFAULT;
				done_d = 1'b1;
			end
		end else if (is_char) begin
			bad_n = bad_d;
			if (ccnt_q != rtc_pkg::CCNT_MAX) begin
				ccnt_d = ccnt_q + 5'd1;
			end
			if (item.last_char) begin
				if (accept_set) begin
					year_d = 14'(14'(yh) * 14'd100 + 14'(yl));
					month_d = two_digits(digits_q[4], digits_q[5]);
					day_d = 8'(two_digits(digits_q[6], digits_q[7]));
					hours_d = two_digits(digits_q[8], digits_q[9]);
					minutes_d = two_digits(digits_q[10], digits_q[11]);
					seconds_d = two_digits(digits_q[12], last_digit);
					valid_d = 1'b1;
					tick_d = '0;
					ivl_d = rtc_pkg::IVL_DEFAULT - last_digit;
					status_d = rtc_pkg::STATUS_ACCEPTED;
				end else begin
					status_d = rtc_pkg::STATUS_REJECTED;
				end
				ccnt_d = '0;
				bad_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= rtc_pkg::TPS_RESET;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hours_q <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			valid_q <= 1'b0;
			ivl_q <= rtc_pkg::IVL_DEFAULT;
			tick_q <= '0;
			ccnt_q <= '0;
			bad_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			year_q <= year_d;
			month_q <= month_d;
			day_q <= day_d;
			hours_q <= hours_d;
			minutes_q <= minutes_d;
			seconds_q <= seconds_d;
			valid_q <= valid_d;
			ivl_q <= ivl_d;
			tick_q <= tick_d;
			ccnt_q <= ccnt_d;
			bad_q <= bad_n;
		end
	end

	always_ff @(posedge clk) begin
		if (is_char && in_range && slot_ok && is_digit) begin
			digits_q[slot] <= digit;
		end
	end

	always_comb begin
		result.year = year_d;
		result.month = month_d;
		result.day = day_d;
		result.hours = hours_d;
		result.minutes = minutes_d;
		result.seconds = seconds_d;
		result.time_valid = valid_d;
		result.set_status = status_d;
		result.interval_done = done_d;
	end

endmodule

@@ rtl/core/rtc_out_reg.sv @@
module rtc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  rtc_pkg::rtc_result_t result_in,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output rtc_pkg::rtc_result_t result_out
);

	logic                valid_q;
	rtc_pkg::rtc_result_t result_q;

	assign free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign result_out = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule
